// ===== rtl/core/bec_pkg.sv =====
// ----------------------------------------------------------------------------
// bec_pkg
// Shared types and constants of the bipartite edge colorer.
// ----------------------------------------------------------------------------
package bec_pkg;

	localparam int unsigned SIDE_W  = 5;
	localparam int unsigned VTX_W   = SIDE_W + 1;
	localparam int unsigned CELL_AW = 2 * SIDE_W;
	localparam int unsigned NBR_AW  = VTX_W + SIDE_W;
	localparam int unsigned CELLS   = 1 << CELL_AW;
	localparam int unsigned NBRS    = 1 << NBR_AW;
	localparam int unsigned STACK_D = 1 << VTX_W;

	localparam logic [5:0] SIDE_N = 6'd32;

	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_LOAD  = 2'd1;
	localparam logic [1:0] MODE_RUN   = 2'd2;
	localparam logic [1:0] MODE_READ  = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [4:0] row_index;
		logic [4:0] col_index;
		logic       edge_present;
	} in_t;

	typedef struct packed {
		logic [5:0] cell_color;
		logic [5:0] max_degree;
		logic       index_error;
	} out_t;

endpackage

// ===== rtl/core/bipartite_edge_colorer.sv =====
// ----------------------------------------------------------------------------
// bipartite_edge_colorer
// Edge coloring of a bipartite graph by alternating path flips.
// ----------------------------------------------------------------------------
// One command at a time. A load answers from the idle state, a read through
// ST_READ. Clear sweeps the presence, color and neighbor memories; after
// reset the same clearing pass runs before the first command is taken. A
// run starts with a sweep of the color and neighbor memories, then reads
// each cell in use, and for each edge searches a free color from 1 up to n
// at both ends, compares the two free colors, walks the alternating path,
// frees the color at the end of the path, flips each edge on the path and
// writes the final link. The memories are read through registers. Colors
// of edges never exceed the largest degree, and max_degree is the largest
// color handed out.
module bipartite_edge_colorer import bec_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_t        in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_t       out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [5:0] cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_READ, ST_CELL_RD, ST_CELL_EV, ST_SCAN_RD, ST_SCAN_EV,
		ST_DECIDE, ST_WALK_RD, ST_WALK_EV, ST_FLIP_CLR, ST_LNK_RD, ST_LNK_GET,
		ST_LW1, ST_LW2
	} state_t;

	typedef enum logic [1:0] {CK_RESET, CK_WIPE, CK_RUN} clr_kind_t;

	logic              pres_mem  [0:CELLS-1];
	logic [5:0]        color_mem [0:CELLS-1];
	logic [5:0]        nbr_mem   [0:NBRS-1];
	logic [VTX_W-1:0]  stack_mem [0:STACK_D-1];

	state_t            st_q;
	clr_kind_t         ck_q;
	logic [NBR_AW-1:0] clr_cnt_q;
	logic [5:0]        n_used_q;
	logic [5:0]        degree_q;
	logic              out_valid_q;
	out_t              out_q;
	logic              rd_err_q;
	logic [4:0]        r_q;
	logic [4:0]        c_q;
	logic              scan_v_q;
	logic [5:0]        f_q;
	logic [5:0]        lu_q;
	logic [5:0]        lv_q;
	logic [5:0]        ori_q;
	logic [5:0]        upd_q;
	logic [VTX_W-1:0]  cur_q;
	logic [VTX_W-1:0]  k_q;
	logic [VTX_W-1:0]  e_q;
	logic [VTX_W-1:0]  a_q;
	logic [VTX_W-1:0]  b_q;
	logic [5:0]        col_q;
	logic              main_q;

	logic              pres_rd;
	logic [5:0]        color_rd;
	logic [5:0]        nbr_rd;
	logic [VTX_W-1:0]  stk_rd;

	logic               pres_we;
	logic [CELL_AW-1:0] pres_wa;
	logic               pres_wd;
	logic               col_we;
	logic [CELL_AW-1:0] col_wa;
	logic [5:0]         col_wd;
	logic [CELL_AW-1:0] col_ra;
	logic               nbr_we;
	logic [NBR_AW-1:0]  nbr_wa;
	logic [5:0]         nbr_wd;
	logic [NBR_AW-1:0]  nbr_ra;
	logic               stk_we;
	logic [VTX_W-1:0]   stk_wa;
	logic [VTX_W-1:0]   stk_wd;

	logic [5:0]        n_eff;
	logic [4:0]        n_m1;
	logic              in_fire;
	logic              in_err;
	logic [VTX_W-1:0]  scan_vtx;
	logic [5:0]        cur_color;
	logic [5:0]        last_free;
	logic [5:0]        slot_m1;
	logic [VTX_W-1:0]  nxt_vtx;
	logic              walk_stop;
	logic [5:0]        min_c;
	logic [5:0]        max_c;
	logic [VTX_W-1:0]  start_vtx;
	logic              last_cell;

	assign in_ready  = (st_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		if (n_used_q == 6'd0) begin
			n_eff = 6'd1;
		end else if (n_used_q > SIDE_N) begin
			n_eff = SIDE_N;
		end else begin
			n_eff = n_used_q;
		end
	end

	assign n_m1      = 5'(n_eff - 6'd1);
	assign in_err    = ({1'b0, in_data.row_index} >= n_eff) ||
		({1'b0, in_data.col_index} >= n_eff);
	assign scan_vtx  = scan_v_q ? {1'b1, c_q} : {1'b0, r_q};
	assign cur_color = k_q[0] ? upd_q : ori_q;
	assign last_free = k_q[0] ? ori_q : upd_q;
	assign slot_m1   = nbr_rd - 6'd1;
	assign nxt_vtx   = {~cur_q[VTX_W-1], slot_m1[SIDE_W-1:0]};
	assign walk_stop = (nbr_rd == 6'd0) || (k_q == {VTX_W{1'b1}});
	assign min_c     = (lu_q < lv_q) ? lu_q : lv_q;
	assign max_c     = (lu_q < lv_q) ? lv_q : lu_q;
	assign start_vtx = (lu_q < lv_q) ? {1'b1, c_q} : {1'b0, r_q};
	assign last_cell = (c_q == 5'd0) && (r_q == n_m1);

	// memory ports
	always_comb begin
		pres_we = 1'b0;
		pres_wa = {in_data.row_index, in_data.col_index};
		pres_wd = in_data.edge_present;
		col_we  = 1'b0;
		col_wa  = {in_data.row_index, in_data.col_index};
		col_wd  = 6'd0;
		nbr_we  = 1'b0;
		nbr_wa  = clr_cnt_q;
		nbr_wd  = 6'd0;
		stk_we  = 1'b0;
		stk_wa  = '0;
		stk_wd  = start_vtx;
		col_ra  = {in_data.row_index, in_data.col_index};
		unique case (st_q)
			ST_SCAN_RD: nbr_ra = {scan_vtx, 5'd0};
			ST_SCAN_EV: nbr_ra = {scan_vtx, f_q[4:0]};
			default:    nbr_ra = {cur_q, 5'(cur_color - 6'd1)};
		endcase
		unique case (st_q)
			ST_IDLE: begin
				if (in_fire && (in_data.mode == MODE_LOAD) && !in_err) begin
					pres_we = 1'b1;
					col_we  = 1'b1;
				end
			end
			ST_CLEAR: begin
				nbr_we  = 1'b1;
				col_we  = 1'b1;
				col_wa  = clr_cnt_q[CELL_AW-1:0];
				pres_we = (ck_q != CK_RUN);
				pres_wa = clr_cnt_q[CELL_AW-1:0];
				pres_wd = 1'b0;
			end
			ST_DECIDE: begin
				stk_we = (lu_q != lv_q);
			end
			ST_WALK_EV: begin
				stk_we = !walk_stop;
				stk_wa = k_q + 1'b1;
				stk_wd = nxt_vtx;
			end
			ST_FLIP_CLR: begin
				nbr_we = 1'b1;
				nbr_wa = {cur_q, 5'(last_free - 6'd1)};
			end
			ST_LW1: begin
				nbr_we = 1'b1;
				nbr_wa = {a_q, 5'(col_q - 6'd1)};
				nbr_wd = {1'b0, b_q[SIDE_W-1:0]} + 6'd1;
			end
			ST_LW2: begin
				nbr_we = 1'b1;
				nbr_wa = {b_q, 5'(col_q - 6'd1)};
				nbr_wd = {1'b0, a_q[SIDE_W-1:0]} + 6'd1;
				col_we = 1'b1;
				col_wa = a_q[VTX_W-1] ? {b_q[SIDE_W-1:0], a_q[SIDE_W-1:0]} :
					{a_q[SIDE_W-1:0], b_q[SIDE_W-1:0]};
				col_wd = col_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pres_we) begin
			pres_mem[pres_wa] <= pres_wd;
		end
		pres_rd <= pres_mem[{r_q, c_q}];
	end

	always_ff @(posedge clk) begin
		if (col_we) begin
			color_mem[col_wa] <= col_wd;
		end
		color_rd <= color_mem[col_ra];
	end

	always_ff @(posedge clk) begin
		if (nbr_we) begin
			nbr_mem[nbr_wa] <= nbr_wd;
		end
		nbr_rd <= nbr_mem[nbr_ra];
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[stk_wa] <= stk_wd;
		end
		stk_rd <= stack_mem[e_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			ck_q        <= CK_RESET;
			clr_cnt_q   <= '0;
			n_used_q    <= SIDE_N;
			degree_q    <= 6'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				n_used_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_fire) begin
						unique case (in_data.mode)
							MODE_CLEAR: begin
								ck_q      <= CK_WIPE;
								clr_cnt_q <= '0;
								degree_q  <= 6'd0;
								st_q      <= ST_CLEAR;
							end
							MODE_RUN: begin
								ck_q      <= CK_RUN;
								clr_cnt_q <= '0;
								degree_q  <= 6'd0;
								st_q      <= ST_CLEAR;
							end
							MODE_LOAD: begin
								out_q       <= '{cell_color: 6'd0, max_degree: degree_q,
									index_error: in_err};
								out_valid_q <= 1'b1;
							end
							MODE_READ: begin
								rd_err_q <= in_err;
								st_q     <= ST_READ;
							end
						endcase
					end
				end
				ST_READ: begin
					out_q       <= '{cell_color: rd_err_q ? 6'd0 : color_rd,
						max_degree: degree_q, index_error: rd_err_q};
					out_valid_q <= 1'b1;
					st_q        <= ST_IDLE;
				end
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == {NBR_AW{1'b1}}) begin
						unique case (ck_q)
							CK_RESET: st_q <= ST_IDLE;
							CK_WIPE: begin
								out_q       <= '{cell_color: 6'd0, max_degree: 6'd0,
									index_error: 1'b0};
								out_valid_q <= 1'b1;
								st_q        <= ST_IDLE;
							end
							CK_RUN: begin
								r_q  <= 5'd0;
								c_q  <= n_m1;
								st_q <= ST_CELL_RD;
							end
							default: st_q <= ST_IDLE;
						endcase
					end
				end
				ST_CELL_RD: st_q <= ST_CELL_EV;
				ST_CELL_EV: begin
					if (pres_rd) begin
						scan_v_q <= 1'b0;
						st_q     <= ST_SCAN_RD;
					end else if (last_cell) begin
						out_q       <= '{cell_color: 6'd0, max_degree: degree_q,
							index_error: 1'b0};
						out_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end else begin
						if (c_q == 5'd0) begin
							r_q <= r_q + 5'd1;
							c_q <= n_m1;
						end else begin
							c_q <= c_q - 5'd1;
						end
						st_q <= ST_CELL_RD;
					end
				end
				ST_SCAN_RD: begin
					f_q  <= 6'd1;
					st_q <= ST_SCAN_EV;
				end
				ST_SCAN_EV: begin
					if ((nbr_rd == 6'd0) || (f_q == n_eff)) begin
						if (scan_v_q) begin
							lv_q <= f_q;
							st_q <= ST_DECIDE;
						end else begin
							lu_q     <= f_q;
							scan_v_q <= 1'b1;
							st_q     <= ST_SCAN_RD;
						end
					end else begin
						f_q <= f_q + 6'd1;
					end
				end
				ST_DECIDE: begin
					if (lu_q == lv_q) begin
						a_q    <= {1'b0, r_q};
						b_q    <= {1'b1, c_q};
						col_q  <= lu_q;
						main_q <= 1'b1;
						st_q   <= ST_LW1;
					end else begin
						ori_q <= min_c;
						upd_q <= max_c;
						cur_q <= start_vtx;
						k_q   <= '0;
						st_q  <= ST_WALK_RD;
					end
				end
				ST_WALK_RD: st_q <= ST_WALK_EV;
				ST_WALK_EV: begin
					if (walk_stop) begin
						st_q <= ST_FLIP_CLR;
					end else begin
						k_q   <= k_q + 1'b1;
						cur_q <= nxt_vtx;
						st_q  <= ST_WALK_RD;
					end
				end
				ST_FLIP_CLR: begin
					if (k_q == '0) begin
						a_q    <= {1'b0, r_q};
						b_q    <= {1'b1, c_q};
						col_q  <= ori_q;
						main_q <= 1'b1;
						st_q   <= ST_LW1;
					end else begin
						b_q  <= cur_q;
						e_q  <= k_q - 1'b1;
						st_q <= ST_LNK_RD;
					end
				end
				ST_LNK_RD: st_q <= ST_LNK_GET;
				ST_LNK_GET: begin
					a_q    <= stk_rd;
					col_q  <= e_q[0] ? ori_q : upd_q;
					main_q <= 1'b0;
					st_q   <= ST_LW1;
				end
				ST_LW1: st_q <= ST_LW2;
				ST_LW2: begin
					if (col_q > degree_q) begin
						degree_q <= col_q;
					end
					if (main_q) begin
						if (last_cell) begin
							out_q       <= '{cell_color: 6'd0,
								max_degree: (col_q > degree_q) ? col_q : degree_q,
								index_error: 1'b0};
							out_valid_q <= 1'b1;
							st_q        <= ST_IDLE;
						end else begin
							if (c_q == 5'd0) begin
								r_q <= r_q + 5'd1;
								c_q <= n_m1;
							end else begin
								c_q <= c_q - 5'd1;
							end
							st_q <= ST_CELL_RD;
						end
					end else if (e_q == '0) begin
						a_q    <= {1'b0, r_q};
						b_q    <= {1'b1, c_q};
						col_q  <= ori_q;
						main_q <= 1'b1;
						st_q   <= ST_LW1;
					end else begin
						b_q  <= a_q;
						e_q  <= e_q - 1'b1;
						st_q <= ST_LNK_RD;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/bec_checker.sv =====
// ----------------------------------------------------------------------------
// bec_checker
// Port-level checks of the bipartite edge colorer.
// ----------------------------------------------------------------------------
module bec_checker import bec_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	// held result stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed before transfer");

	// colors never exceed the degree bound
	a_color_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.cell_color <= out_data.max_degree)
		else $error("color above max degree");

	a_err_color: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.index_error |-> out_data.cell_color == 6'd0)
		else $error("flagged index with a color");

endmodule

bind bipartite_edge_colorer bec_checker u_bec_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);
